### src/clt_pkg.sv
// Shared types and constants for the command line tokenizer.
// No dependencies; imported by clt_parser and the top level.
package clt_pkg;

  // Default limits, used as the defaults of the top-level and parser parameters
  localparam int MAX_ARGS_DEFAULT    = 16;
  localparam int MAX_ARG_LEN_DEFAULT = 1024;

  // Character codes the parser reacts to
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [2:0] {
    MODE_BETWEEN    = 3'd0,
    MODE_QUOTED     = 3'd1,
    MODE_UNQUOTED   = 3'd2,
    MODE_COMMENT    = 3'd3,
    MODE_EXPECT_EOL = 3'd4
  } parse_mode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_UNEXPECTED = 2'd1,
    ST_TOO_MANY   = 2'd2,
    ST_TOO_LONG   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] arg_byte;
    logic       byte_valid;
    logic [3:0] arg_index;
    logic       arg_done;
    logic       line_done;
    logic [4:0] arg_count;
    logic       background;
    status_t    status;
  } clt_result_t;

  localparam int RES_W = $bits(clt_result_t);

endpackage

### src/clt_stage.sv
// Generic valid/ready register stage: one transaction of W bits held.
// No package dependencies; used for the input and the result register.
module clt_stage #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  logic [W-1:0] up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output logic [W-1:0] dn_data
);

  logic         valid_r;
  logic         valid_nxt;
  logic [W-1:0] data_r;
  logic         load;

  // Load whenever the stage is empty or the held transaction leaves in this same cycle
  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (dn_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= up_data;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

### src/clt_parser.sv
// Tokenizer parse state and per-character next-state / result logic.
// Depends on clt_pkg (mode and status enums, result struct, char codes).
module clt_parser #(
  parameter int MAX_ARGUMENTS  = clt_pkg::MAX_ARGS_DEFAULT,
  parameter int MAX_ARG_LENGTH = clt_pkg::MAX_ARG_LEN_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  logic [7:0]           char_in,
  output clt_pkg::clt_result_t res
);
  import clt_pkg::*;

  localparam int CNT_W = $clog2(MAX_ARGUMENTS + 1);
  localparam int LEN_W = $clog2(MAX_ARG_LENGTH + 1);

  parse_mode_t      mode_r,   mode_nxt;
  logic [LEN_W-1:0] len_r,    len_nxt;
  logic [CNT_W-1:0] args_r,   args_nxt;
  logic             bg_r,     bg_nxt;

  logic             is_eol;
  logic             is_space;
  logic             args_full;
  logic [LEN_W-1:0] len_inc;
  logic             len_hit;
  logic [CNT_W+4:0] idx_ext;
  logic [CNT_W+4:0] cnt_ext;

  assign is_eol   = (char_in == CH_CR) || (char_in == CH_LF) || (char_in == CH_NUL);
  assign is_space = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
  assign args_full = args_r >= CNT_W'(MAX_ARGUMENTS);
  assign len_inc   = len_r + LEN_W'(1);
  assign len_hit   = len_inc >= LEN_W'(MAX_ARG_LENGTH);
  assign idx_ext   = {5'd0, args_r};

  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    args_nxt = args_r;
    bg_nxt   = bg_r;
    cnt_ext  = '0;
    res            = '0;
    res.arg_index  = idx_ext[3:0];
    res.status     = ST_OK;

    case (mode_r)
      MODE_BETWEEN: begin
        if (char_in == CH_HASH) begin
          mode_nxt = MODE_COMMENT;
        end else if (char_in == CH_AMP) begin
          mode_nxt = MODE_EXPECT_EOL;
          bg_nxt   = 1'b1;
        end else if (is_eol) begin
          res.line_done = 1'b1;
        end else if (is_space) begin
          // skip whitespace between arguments
        end else if (args_full) begin
          res.line_done = 1'b1;
          res.status    = ST_TOO_MANY;
        end else if (char_in == CH_QUOTE) begin
          len_nxt  = '0;
          mode_nxt = MODE_QUOTED;
        end else begin
          len_nxt        = LEN_W'(1);
          res.arg_byte   = char_in;
          res.byte_valid = 1'b1;
          mode_nxt       = MODE_UNQUOTED;
        end
      end
      MODE_QUOTED: begin
        if (char_in == CH_QUOTE) begin
          res.arg_done = 1'b1;
          args_nxt     = args_r + CNT_W'(1);
          mode_nxt     = MODE_BETWEEN;
        end else if (is_eol) begin
          res.line_done = 1'b1;
          res.status    = ST_UNEXPECTED;
        end else begin
          len_nxt = len_inc;
          if (len_hit) begin
            res.line_done = 1'b1;
            res.status    = ST_TOO_LONG;
          end else begin
            res.arg_byte   = char_in;
            res.byte_valid = 1'b1;
          end
        end
      end
      MODE_UNQUOTED: begin
        if (char_in == CH_QUOTE) begin
          res.line_done = 1'b1;
          res.status    = ST_UNEXPECTED;
        end else if (char_in == CH_HASH || char_in == CH_AMP || is_eol || is_space) begin
          res.arg_done = 1'b1;
          args_nxt     = args_r + CNT_W'(1);
          if (char_in == CH_HASH) begin
            mode_nxt = MODE_COMMENT;
          end else if (char_in == CH_AMP) begin
            mode_nxt = MODE_EXPECT_EOL;
            bg_nxt   = 1'b1;
          end else if (is_eol) begin
            res.line_done = 1'b1;
          end else begin
            mode_nxt = MODE_BETWEEN;
          end
        end else begin
          len_nxt = len_inc;
          if (len_hit) begin
            res.line_done = 1'b1;
            res.status    = ST_TOO_LONG;
          end else begin
            res.arg_byte   = char_in;
            res.byte_valid = 1'b1;
          end
        end
      end
      MODE_COMMENT: begin
        if (is_eol) begin
          res.line_done = 1'b1;
        end
      end
      MODE_EXPECT_EOL: begin
        if (is_eol) begin
          res.line_done = 1'b1;
        end else if (!is_space) begin
          res.line_done = 1'b1;
          res.status    = ST_UNEXPECTED;
        end
      end
      default: begin
        mode_nxt = MODE_BETWEEN;
      end
    endcase

    // Counts reported after this character, before any line clear
    cnt_ext        = {5'd0, args_nxt};
    res.arg_count  = cnt_ext[4:0];
    res.background = bg_nxt;

    // Line end or error: drop all line state
    if (res.line_done) begin
      mode_nxt = MODE_BETWEEN;
      len_nxt  = '0;
      args_nxt = '0;
      bg_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BETWEEN;
      len_r  <= '0;
      args_r <= '0;
      bg_r   <= 1'b0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      args_r <= args_nxt;
      bg_r   <= bg_nxt;
    end
  end

  a_byte_not_at_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    res.byte_valid |-> !res.line_done)
    else $error("argument byte reported together with line end");

  a_error_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (res.status != ST_OK) |-> res.line_done)
    else $error("error status without line end");

  a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.line_done) |=>
      (args_r == '0 && mode_r == MODE_BETWEEN && !bg_r && len_r == '0))
    else $error("line state not cleared after line end");

  a_args_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    args_r <= CNT_W'(MAX_ARGUMENTS))
    else $error("argument count beyond limit");

endmodule

### src/command_line_tokenizer_top.sv
// Top level of the command line tokenizer: input register, parser, result register.
// Depends on clt_pkg, clt_stage and clt_parser.
//
// The tokenizer takes one raw character per input transaction and returns exactly one
// result transaction for it: the byte appended to the current argument (if any), the
// argument index, argument and line end flags, the running argument count, the
// background flag and a status code (ok, unexpected token, too many arguments, argument
// too long). A line end (CR, LF, NUL) or any error clears the parser for the next line.
// Throughput is one character per clock while the output is not stalled; the character is
// held in the input register, and its result is held in the result register until taken.
// The parser's state update sits between the input register and the result register
// and advances once per character.
// Both stages accept a new transaction while the held one leaves, so a stalled output
// holds at most two characters in flight. No configuration and no reset sweep.
module command_line_tokenizer_top #(
  parameter int MAX_ARGUMENTS  = clt_pkg::MAX_ARGS_DEFAULT,
  parameter int MAX_ARG_LENGTH = clt_pkg::MAX_ARG_LEN_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_arg_byte,
  output logic       out_byte_valid,
  output logic [3:0] out_arg_index,
  output logic       out_arg_done,
  output logic       out_line_done,
  output logic [4:0] out_arg_count,
  output logic       out_background,
  output logic [1:0] out_status
);
  import clt_pkg::*;

  // Registered character waiting for the parser
  logic             ch_valid;
  logic             ch_ready;
  logic [7:0]       ch_data;
  logic             step_en;

  clt_result_t      res;
  clt_result_t      res_q;
  logic [RES_W-1:0] res_vec;
  logic [RES_W-1:0] res_q_vec;

  clt_stage #(.W(8)) u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_char_in),
    .dn_valid (ch_valid),
    .dn_ready (ch_ready),
    .dn_data  (ch_data)
  );

  // Advance the parse state exactly when the character moves into the result register
  assign step_en = ch_valid && ch_ready;

  clt_parser #(
    .MAX_ARGUMENTS  (MAX_ARGUMENTS),
    .MAX_ARG_LENGTH (MAX_ARG_LENGTH)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .char_in (ch_data),
    .res     (res)
  );

  assign res_vec = res;

  clt_stage #(.W(RES_W)) u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ch_valid),
    .up_ready (ch_ready),
    .up_data  (res_vec),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (res_q_vec)
  );

  assign res_q = clt_result_t'(res_q_vec);

  // Unpack the held result onto the output ports
  assign out_arg_byte   = res_q.arg_byte;
  assign out_byte_valid = res_q.byte_valid;
  assign out_arg_index  = res_q.arg_index;
  assign out_arg_done   = res_q.arg_done;
  assign out_line_done  = res_q.line_done;
  assign out_arg_count  = res_q.arg_count;
  assign out_background = res_q.background;
  assign out_status     = res_q.status;

endmodule
